### src/art_pkg.sv
// ---------------------------------------------------------------------------
// art_pkg: shared types and constants of the angular rainbow texture
// Shape codes, hue segment bounds, the arctangent table and stage structs.
// ---------------------------------------------------------------------------
package art_pkg;

    // shape codes on the kind field
    localparam logic [2:0] KIND_SPHERE   = 3'd0;
    localparam logic [2:0] KIND_PLANE    = 3'd1;
    localparam logic [2:0] KIND_CYLINDER = 3'd2;
    localparam logic [2:0] KIND_CONE     = 3'd3;

    localparam int KIND_W  = 3;
    localparam int COORD_W = 32;
    localparam int HUE_W   = 11;
    localparam int CH_W    = 8;

    // hue segment bounds
    localparam logic [HUE_W-1:0] HUE_SEG1 = 11'd255;
    localparam logic [HUE_W-1:0] HUE_SEG2 = 11'd510;
    localparam logic [HUE_W-1:0] HUE_HALF = 11'd765;
    localparam logic [HUE_W-1:0] HUE_SEG4 = 11'd1020;
    localparam logic [HUE_W-1:0] HUE_SEG5 = 11'd1275;
    localparam logic [HUE_W-1:0] HUE_FULL = 11'd1530;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;

    // CORDIC datapath: 33-bit difference scaled up by 2^PRESCALE, plus growth
    localparam int PRESCALE        = 28;
    localparam int CW              = 64;
    localparam int ANG_W           = 32;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam logic [ANG_W-1:0] ANGLE_HALF = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANG_W-1:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [1:0] {
        KC_ANGULAR,
        KC_PLANE,
        KC_OTHER
    } kclass_t;

    // per-item flags that travel with the CORDIC stages
    typedef struct packed {
        kclass_t kc;
        logic    axis;   // dy is zero
        logic    neg;    // dx is negative
    } meta_t;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [HUE_W-1:0] hue;
    } res_t;

endpackage

### src/art_if.sv
// ---------------------------------------------------------------------------
// art_if: valid/ready channels of the angular rainbow texture
// One channel carries hit samples in, the other carries colors out.
// ---------------------------------------------------------------------------
interface art_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [art_pkg::KIND_W-1:0]           kind;
    logic signed [art_pkg::COORD_W-1:0]   obj_x;
    logic signed [art_pkg::COORD_W-1:0]   obj_y;
    logic signed [art_pkg::COORD_W-1:0]   hit_x;
    logic signed [art_pkg::COORD_W-1:0]   hit_y;

    modport source (output valid, kind, obj_x, obj_y, hit_x, hit_y, input ready);
    modport sink   (input valid, kind, obj_x, obj_y, hit_x, hit_y, output ready);
endinterface

interface art_shade_if;
    logic                         valid;
    logic                         ready;
    logic [art_pkg::CH_W-1:0]     red;
    logic [art_pkg::CH_W-1:0]     green;
    logic [art_pkg::CH_W-1:0]     blue;
    logic [art_pkg::HUE_W-1:0]    hue;

    modport source (output valid, red, green, blue, hue, input ready);
    modport sink   (input valid, red, green, blue, hue, output ready);
endinterface

### src/angular_rainbow_texture.sv
// ---------------------------------------------------------------------------
// angular_rainbow_texture: hue wheel color from the angle around an object
// Pipelined CORDIC atan2 or planar distance hue, mapped to 8-bit RGB.
// ---------------------------------------------------------------------------
// Usage:
//   sample (sink): kind, object and hit positions x/y in signed Q15.16.
//   shade (source): red, green, blue and the hue 0..1530.
//   One item per cycle enters while valid and ready are high; every item
//   gives exactly one color, in order.
//   Registers from acceptance to shade.valid: input difference, prescale,
//   one CORDIC step per stage, hue multiply, color map, output register.
//   Throughput: one item per cycle while the skid is empty; each CORDIC step
//   owns a stage, so the unrolled rotation chain sets the depth but not the rate.
//   Stall: a skid register behind the output register takes the one item in
//   flight when shade.ready drops; once it fills, sample.ready goes low and
//   the whole pipeline holds. Bubbles still move while the skid is empty.
//   Reset: clears all valid bits; no item is in flight afterwards.
//   FRAC_BITS sets the fixed-point scale of the planar distance hue.
// ---------------------------------------------------------------------------
module angular_rainbow_texture #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    art_sample_if.sink   sample,
    art_shade_if.source  shade
);

    localparam int N  = (CORDIC_ITERS > art_pkg::ANGLE_TABLE_LEN) ?
                        art_pkg::ANGLE_TABLE_LEN : CORDIC_ITERS;
    localparam int ST = N + 4;     // diff, prescale, N rotations, hue mul, map

    localparam int CW    = art_pkg::CW;
    localparam int ANG_W = art_pkg::ANG_W;
    localparam int HUE_W = art_pkg::HUE_W;
    localparam int DW    = art_pkg::COORD_W + 1;

    // plane hue: floor(|dx|*200 / 2^FRAC_BITS) mod 1530 by reciprocal
    localparam int AMW   = DW + 8;                 // |dx| * 200
    localparam int PW    = AMW - FRAC_BITS;        // scaled distance
    localparam int RK    = PW + 11;
    localparam int RW    = PW + 1;
    localparam int PPW   = PW + RW;
    localparam int QW    = PPW - RK;
    localparam int REMW  = 12;                     // remainder below 3060
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << RK) / 64'd1530);
    localparam int HPW   = ANG_W + HUE_W;

    // ---------------------------------------------------------------- control
    logic          adv;
    logic [ST-1:0] vld_reg;
    logic          skid_vld_reg;
    logic          out_vld_reg;

    assign adv          = !skid_vld_reg;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ST-2:0], sample.valid};
        end
    end

    // ---------------------------------------------------------------- stage 0
    art_pkg::kclass_t     kc_in;
    art_pkg::kclass_t     kc0_reg;
    logic signed [DW-1:0] dx0_reg;
    logic signed [DW-1:0] dy0_reg;

    always_comb
    begin
        unique case (sample.kind)
            art_pkg::KIND_SPHERE,
            art_pkg::KIND_CYLINDER,
            art_pkg::KIND_CONE:  kc_in = art_pkg::KC_ANGULAR;
            art_pkg::KIND_PLANE: kc_in = art_pkg::KC_PLANE;
            default:             kc_in = art_pkg::KC_OTHER;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kc0_reg <= kc_in;
            dx0_reg <= {sample.obj_x[art_pkg::COORD_W-1], sample.obj_x}
                     - {sample.hit_x[art_pkg::COORD_W-1], sample.hit_x};
            dy0_reg <= {sample.obj_y[art_pkg::COORD_W-1], sample.obj_y}
                     - {sample.hit_y[art_pkg::COORD_W-1], sample.hit_y};
        end
    end

    // ---------------------------------------------------------------- stage 1
    art_pkg::meta_t       m1_reg;
    logic signed [CW-1:0] x1_reg;
    logic signed [CW-1:0] y1_reg;
    logic [ANG_W-1:0]     z1_reg;
    logic [PW-1:0]        pv1_reg;

    logic                 neg0;
    logic signed [CW-1:0] dxe;
    logic signed [CW-1:0] dye;
    logic [DW-1:0]        dabs;
    logic [AMW-1:0]       dmul;

    always_comb
    begin
        neg0 = dx0_reg[DW-1];
        dxe  = CW'(dx0_reg);
        dye  = CW'(dy0_reg);
        // the largest difference magnitude is 2^32-1, so the negation fits, read unsigned
        dabs = neg0 ? (~dx0_reg + 1'b1) : dx0_reg;
        dmul = AMW'(dabs) * AMW'(200);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg.kc   <= kc0_reg;
            m1_reg.axis <= (dy0_reg == '0);
            m1_reg.neg  <= neg0;
            // move the vector into the right half plane
            x1_reg      <= (neg0 ? -dxe : dxe) <<< art_pkg::PRESCALE;
            y1_reg      <= (neg0 ? -dye : dye) <<< art_pkg::PRESCALE;
            z1_reg      <= neg0 ? art_pkg::ANGLE_HALF : '0;
            pv1_reg     <= PW'(dmul >> FRAC_BITS);
        end
    end

    // ------------------------------------------------------------ CORDIC body
    logic signed [CW-1:0] cx_reg [N];
    logic signed [CW-1:0] cy_reg [N];
    logic [ANG_W-1:0]     cz_reg [N];
    art_pkg::meta_t       cm_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_cordic
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic [ANG_W-1:0]     zi;
        art_pkg::meta_t       mi;

        if (j == 0)
        begin : g_first
            assign xi = x1_reg;
            assign yi = y1_reg;
            assign zi = z1_reg;
            assign mi = m1_reg;
        end
        else
        begin : g_rest
            assign xi = cx_reg[j-1];
            assign yi = cy_reg[j-1];
            assign zi = cz_reg[j-1];
            assign mi = cm_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // rotate toward the x axis, accumulate the angle
                if (!yi[CW-1])
                begin
                    cx_reg[j] <= xi + (yi >>> j);
                    cy_reg[j] <= yi - (xi >>> j);
                    cz_reg[j] <= zi + art_pkg::ANGLE_STEP[j];
                end
                else
                begin
                    cx_reg[j] <= xi - (yi >>> j);
                    cy_reg[j] <= yi + (xi >>> j);
                    cz_reg[j] <= zi - art_pkg::ANGLE_STEP[j];
                end
                cm_reg[j] <= mi;
            end
        end
    end

    // ------------------------------------------- plane hue beside the CORDIC
    logic [PPW-1:0]   pprod_reg;
    logic [PW-1:0]    pvc0_reg;
    logic [REMW-1:0]  prem_reg;
    logic [HUE_W-1:0] phue_reg [N-2];
    logic [QW-1:0]    pq;

    assign pq = pprod_reg[PPW-1:RK];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pprod_reg <= PPW'(pv1_reg) * PPW'(RECIP);
            pvc0_reg  <= pv1_reg;
            // quotient estimate is exact or one short
            prem_reg  <= REMW'(pvc0_reg) - REMW'(pq * 12'd1530);
            phue_reg[0] <= (prem_reg >= REMW'(art_pkg::HUE_FULL)) ?
                           HUE_W'(prem_reg - REMW'(art_pkg::HUE_FULL)) :
                           HUE_W'(prem_reg);
            for (int k = 1; k < N - 2; k++)
            begin
                phue_reg[k] <= phue_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------- hue multiply
    art_pkg::meta_t   mh_reg;
    logic [HUE_W-1:0] hang_reg;
    logic [HUE_W-1:0] hpl_reg;
    logic [ANG_W-1:0] hturn;
    logic [HPW-1:0]   hprod;

    // shift the angle by a half turn, wrapping at a full turn
    assign hturn = cz_reg[N-1] + art_pkg::ANGLE_HALF;
    assign hprod = HPW'(hturn) * HPW'(art_pkg::HUE_FULL);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mh_reg   <= cm_reg[N-1];
            hang_reg <= hprod[HPW-1:ANG_W];
            hpl_reg  <= phue_reg[N-3];
        end
    end

    // --------------------------------------------------------- color map
    art_pkg::res_t    res_next;
    art_pkg::res_t    res_reg;
    logic [HUE_W-1:0] h;

    always_comb
    begin
        unique case (mh_reg.kc)
            art_pkg::KC_ANGULAR:
            begin
                if (mh_reg.axis)
                begin
                    h = mh_reg.neg ? art_pkg::HUE_FULL : art_pkg::HUE_HALF;
                end
                else
                begin
                    h = hang_reg;
                end
            end
            art_pkg::KC_PLANE: h = hpl_reg;
            default:           h = '0;
        endcase

        res_next.hue = h;
        priority if (h < art_pkg::HUE_SEG1)
        begin
            res_next.red   = art_pkg::CH_MAX;
            res_next.green = h[7:0];
            res_next.blue  = '0;
        end
        else if (h < art_pkg::HUE_SEG2)
        begin
            res_next.red   = 8'(art_pkg::HUE_SEG2 - h);
            res_next.green = art_pkg::CH_MAX;
            res_next.blue  = '0;
        end
        else if (h < art_pkg::HUE_HALF)
        begin
            res_next.red   = '0;
            res_next.green = art_pkg::CH_MAX;
            res_next.blue  = 8'(h - art_pkg::HUE_SEG2);
        end
        else if (h < art_pkg::HUE_SEG4)
        begin
            res_next.red   = '0;
            res_next.green = 8'(art_pkg::HUE_SEG4 - h);
            res_next.blue  = art_pkg::CH_MAX;
        end
        else if (h < art_pkg::HUE_SEG5)
        begin
            res_next.red   = 8'(h - art_pkg::HUE_SEG4);
            res_next.green = '0;
            res_next.blue  = art_pkg::CH_MAX;
        end
        else
        begin
            res_next.red   = art_pkg::CH_MAX;
            res_next.green = '0;
            res_next.blue  = 8'(art_pkg::HUE_FULL - h);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------- output and skid
    art_pkg::res_t out_reg;
    art_pkg::res_t skid_reg;
    logic          last_vld;

    assign last_vld = vld_reg[ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || shade.ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg  <= last_vld;
            end
        end
        else if (last_vld && adv)
        begin
            // park the item in flight while the receiver stalls
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || shade.ready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_reg;
        end
        else if (last_vld && adv)
        begin
            skid_reg <= res_reg;
        end
    end

    assign shade.valid = out_vld_reg;
    assign shade.red   = out_reg.red;
    assign shade.green = out_reg.green;
    assign shade.blue  = out_reg.blue;
    assign shade.hue   = out_reg.hue;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && !shade.ready) |=> skid_vld_reg)
        else $error("skid item dropped during stall");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.hue <= art_pkg::HUE_FULL))
        else $error("hue out of range");

    a_color_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.red == art_pkg::CH_MAX ||
                         out_reg.green == art_pkg::CH_MAX ||
                         out_reg.blue == art_pkg::CH_MAX))
        else $error("rainbow color without a saturated channel");
`endif

endmodule

### sim/tb_angular_rainbow_texture.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_angular_rainbow_texture: self-checking bench for the rainbow texture
// Drives hit samples through the valid/ready sample channel. A bit-accurate
// CORDIC atan2 and planar hue predictor computes each accepted sample's
// color, and every shade item is checked field by field in order. Sender and
// receiver stalls change over three phases.
// ---------------------------------------------------------------------------
module tb_angular_rainbow_texture;

    localparam int FRAC_Q      = 16;
    localparam int ROT_STEPS   = 16;
    localparam int PIPE_DEPTH  = ROT_STEPS + 5;
    localparam int N_RANDOM    = 1400;
    localparam int PHASE_LEN   = 475;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHIFT_UP    = 28;
    localparam int ROT_TABLE   = 24;

    typedef struct {
        logic [art_pkg::KIND_W-1:0]         kind;
        logic signed [art_pkg::COORD_W-1:0] obj_x;
        logic signed [art_pkg::COORD_W-1:0] obj_y;
        logic signed [art_pkg::COORD_W-1:0] hit_x;
        logic signed [art_pkg::COORD_W-1:0] hit_y;
    } sample_t;

    typedef struct {
        logic [art_pkg::CH_W-1:0]  red;
        logic [art_pkg::CH_W-1:0]  green;
        logic [art_pkg::CH_W-1:0]  blue;
        logic [art_pkg::HUE_W-1:0] hue;
    } color_t;

    // atan(2^-i), 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [ROT_TABLE] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    logic clk;
    logic rst_n;

    art_sample_if sample();
    art_shade_if  shade();

    angular_rainbow_texture #(
        .FRAC_BITS    (FRAC_Q),
        .CORDIC_ITERS (ROT_STEPS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .shade  (shade)
    );

    sample_t samples_to_send[$];
    color_t  colors_due[$];
    int      samples_in;
    int      mismatches;
    int      cycles;
    logic    sample_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // color predictor
    // ------------------------------------------------------------------
    function automatic int angle_hue(longint dx, longint dy);
        longint            x;
        longint            y;
        longint            xs;
        longint            ys;
        logic [31:0]       z;
        logic [31:0]       t;
        longint unsigned   prod;
        int                steps;
        if (dy == 0)
            return (dx < 0) ? 1530 : 765;
        x = dx * (64'sd1 <<< SHIFT_UP);
        y = dy * (64'sd1 <<< SHIFT_UP);
        z = '0;
        // fold the left half plane over, starting at a half turn
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        steps = (ROT_STEPS > ROT_TABLE) ? ROT_TABLE : ROT_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        t = z + 32'h8000_0000;
        prod = 64'(t) * 64'd1530;
        return int'(prod >> 32);
    endfunction

    function automatic int plane_hue(longint dx);
        longint unsigned mag;
        mag = (dx < 0) ? longint'(-dx) : longint'(dx);
        return int'(((mag * 200) >> FRAC_Q) % 1530);
    endfunction

    function automatic color_t shade_of_sample(sample_t s);
        longint dx;
        longint dy;
        int     h;
        color_t c;
        dx = longint'(s.obj_x) - longint'(s.hit_x);
        dy = longint'(s.obj_y) - longint'(s.hit_y);
        if (s.kind == art_pkg::KIND_SPHERE || s.kind == art_pkg::KIND_CYLINDER
            || s.kind == art_pkg::KIND_CONE)
            h = angle_hue(dx, dy);
        else if (s.kind == art_pkg::KIND_PLANE)
            h = plane_hue(dx);
        else
            h = 0;
        if (h < 255)
        begin
            c.red = 8'd255;          c.green = 8'(h);        c.blue = 8'd0;
        end
        else if (h < 510)
        begin
            c.red = 8'(510 - h);     c.green = 8'd255;       c.blue = 8'd0;
        end
        else if (h < 765)
        begin
            c.red = 8'd0;            c.green = 8'd255;       c.blue = 8'(h - 510);
        end
        else if (h < 1020)
        begin
            c.red = 8'd0;            c.green = 8'(1020 - h); c.blue = 8'd255;
        end
        else if (h < 1275)
        begin
            c.red = 8'(h - 1020);    c.green = 8'd0;         c.blue = 8'd255;
        end
        else
        begin
            c.red = 8'd255;          c.green = 8'd0;         c.blue = 8'(1530 - h);
        end
        c.hue = art_pkg::HUE_W'(h);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_sample(input logic [art_pkg::KIND_W-1:0] k, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] hx,
                              input logic [31:0] hy);
        sample_t s;
        s.kind  = k;
        s.obj_x = ox;
        s.obj_y = oy;
        s.hit_x = hx;
        s.hit_y = hy;
        samples_to_send.push_back(s);
    endtask

    // signed offset with a random magnitude, from a few LSBs up to full range
    function automatic logic [31:0] rand_offset();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic int send_idle_pct();
        if (samples_in < PHASE_LEN)
            return 34;
        else if (samples_in < 2 * PHASE_LEN)
            return 82;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (samples_in < PHASE_LEN)
            return 82;
        else if (samples_in < 2 * PHASE_LEN)
            return 34;
        return 0;
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver and receiver stalls, both at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        sample_t s;
        // hold an item until it is taken
        if (sample_taken || !sample.valid)
        begin
            if (rst_n && samples_to_send.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct())
            begin
                s = samples_to_send.pop_front();
                sample.valid <= 1'b1;
                sample.kind  <= s.kind;
                sample.obj_x <= s.obj_x;
                sample.obj_y <= s.obj_y;
                sample.hit_x <= s.hit_x;
                sample.hit_y <= s.hit_y;
            end
            else
            begin
                sample.valid <= 1'b0;
            end
        end
        shade.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // ------------------------------------------------------------------
    // monitor and checker at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t s;
        color_t  want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            sample_taken <= sample.valid && sample.ready;
            if (sample.valid && sample.ready)
            begin
                s.kind  = sample.kind;
                s.obj_x = sample.obj_x;
                s.obj_y = sample.obj_y;
                s.hit_x = sample.hit_x;
                s.hit_y = sample.hit_y;
                colors_due.push_back(shade_of_sample(s));
                samples_in <= samples_in + 1;
            end
            if (shade.valid && shade.ready)
            begin
                if (colors_due.size() == 0)
                begin
                    note_failure($sformatf("color with none due: r=%0d g=%0d b=%0d hue=%0d",
                                           shade.red, shade.green, shade.blue, shade.hue));
                end
                else
                begin
                    want = colors_due.pop_front();
                    if (shade.red !== want.red)
                        note_failure($sformatf("red exp %0d got %0d", want.red, shade.red));
                    if (shade.green !== want.green)
                        note_failure($sformatf("green exp %0d got %0d",
                                               want.green, shade.green));
                    if (shade.blue !== want.blue)
                        note_failure($sformatf("blue exp %0d got %0d", want.blue, shade.blue));
                    if (shade.hue !== want.hue)
                        note_failure($sformatf("hue exp %0d got %0d", want.hue, shade.hue));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [art_pkg::KIND_W-1:0] k;
        logic [31:0]                ox;
        logic [31:0]                oy;
        logic [31:0]                hx;
        logic [31:0]                hy;
        int                         pick;

        rst_n        = 1'b0;
        sample_taken = 1'b0;
        samples_in   = 0;
        mismatches   = 0;
        cycles       = 0;
        sample.valid = 1'b0;
        sample.kind  = '0;
        sample.obj_x = '0;
        sample.obj_y = '0;
        sample.hit_x = '0;
        sample.hit_y = '0;
        shade.ready  = 1'b0;

        // zero vector, both axes, both signs
        add_sample(art_pkg::KIND_SPHERE,   32'd0, 32'd0, 32'd0, 32'd0);
        add_sample(art_pkg::KIND_SPHERE,   32'd5000, 32'd7, 32'd0, 32'd7);
        add_sample(art_pkg::KIND_SPHERE,   32'd0, 32'd7, 32'd5000, 32'd7);
        add_sample(art_pkg::KIND_CYLINDER, 32'd3, 32'd900, 32'd3, 32'd0);
        add_sample(art_pkg::KIND_CONE,     32'd3, 32'd0, 32'd3, 32'd900);
        // largest differences in every quadrant
        add_sample(art_pkg::KIND_SPHERE,   32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000);
        add_sample(art_pkg::KIND_SPHERE,   32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(art_pkg::KIND_CYLINDER, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(art_pkg::KIND_CONE,     32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000);
        // smallest nonzero differences
        add_sample(art_pkg::KIND_SPHERE,   32'd1, 32'd1, 32'd0, 32'd0);
        add_sample(art_pkg::KIND_CONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        add_sample(art_pkg::KIND_CYLINDER, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
        // large dx against tiny dy, near the negative x axis
        add_sample(art_pkg::KIND_SPHERE,   32'h8000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'd0);
        // plane: extremes, zero, one unit, just below the wrap of the hue
        add_sample(art_pkg::KIND_PLANE,    32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0);
        add_sample(art_pkg::KIND_PLANE,    32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'd0);
        add_sample(art_pkg::KIND_PLANE,    32'd0, 32'd0, 32'd0, 32'd0);
        add_sample(art_pkg::KIND_PLANE,    32'h0001_0000, 32'd0, 32'd0, 32'd0);
        add_sample(art_pkg::KIND_PLANE,    32'd0, 32'd0, 32'd501350, 32'd0);
        // other kinds, then a sphere with dx zero
        for (int i = 4; i < 8; i++)
            add_sample(art_pkg::KIND_W'(i), $urandom, $urandom, $urandom, $urandom);
        add_sample(art_pkg::KIND_SPHERE,   32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0001);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                k = art_pkg::KIND_W'($urandom_range(0, 7));
            else
                k = art_pkg::KIND_W'($urandom_range(0, 3));
            ox = $urandom;
            oy = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                hx = $urandom;
                hy = $urandom;
            end
            else if (pick < 45)
            begin
                // on an axis
                hx = ($urandom_range(0, 1) == 0) ? ox : ox - rand_offset();
                hy = (hx == ox) ? oy - rand_offset() : oy;
            end
            else
            begin
                hx = ox - rand_offset();
                hy = oy - rand_offset();
            end
            add_sample(k, ox, oy, hx, hy);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (samples_to_send.size() != 0 || sample.valid)
            @(posedge clk);
        while (colors_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);

        if (colors_due.size() != 0)
            note_failure($sformatf("%0d colors never arrived", colors_due.size()));
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
